// File: rtl/lpdt_pkg.sv
// Shared types and constants for the linear-probe define table.
`timescale 1ns / 1ps
package lpdt_pkg;

  localparam int KEY_W     = 32;
  localparam int NAME_ID_W = 16;
  localparam int STATUS_W  = 2;
  localparam int HANDLE_W  = 9;

  // Handles are the define index offset by this base; zero means none.
  localparam int HANDLE_BASE = 4;

  localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  // Source of the result handle.
  typedef enum logic [1:0] {
    RES_NONE,   // zero
    RES_NEW,    // entry just allocated
    RES_SLOT    // entry referenced by the slot just read
  } res_sel_e;

  typedef struct packed {
    logic                load_item;
    logic                clear;
    logic                rd_slot;
    logic                rd_name;
    logic                step;
    logic                insert;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    res_sel_e            res_sel;
  } cmd_t;

  typedef struct packed {
    logic is_insert;
    logic key_zero;
    logic slot_empty;
    logic key_match;
    logic name_match;
    logic entry_avail;
    logic last_probe;
    logic last_slot;
  } sts_t;

endpackage

// File: rtl/lpdt_in_if.sv
// Request channel: lookup or insert beats.
`timescale 1ns / 1ps
interface lpdt_in_if import lpdt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [KEY_W-1:0]     key;
  logic [NAME_ID_W-1:0] name_id;

  modport source (output valid, kind, key, name_id, input ready);
  modport sink   (input valid, kind, key, name_id, output ready);
endinterface

// File: rtl/lpdt_out_if.sv
// Result channel: status and handle beats.
`timescale 1ns / 1ps
interface lpdt_out_if import lpdt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, status, handle, input ready);
  modport sink   (input valid, status, handle, output ready);
endinterface

// File: rtl/lpdt_dp.sv
// Datapath: slot and entry memories, probe pointer, entry count, result register.
`timescale 1ns / 1ps
module lpdt_dp import lpdt_pkg::*; #(
  parameter int SLOT_BITS      = 9,
  parameter int ENTRY_CAPACITY = 256,
  parameter int NAME_BITS      = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 kind_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic [NAME_ID_W-1:0] name_id_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [HANDLE_W-1:0]  handle_o
);

  localparam int SLOT_COUNT = 1 << SLOT_BITS;
  localparam int IDX_W      = $clog2(ENTRY_CAPACITY);
  localparam int CNT_W      = $clog2(ENTRY_CAPACITY + 1);
  localparam int NB         = (NAME_BITS < NAME_ID_W) ? NAME_BITS : NAME_ID_W;

  logic [KEY_W-1:0] slot_key   [SLOT_COUNT];
  logic [IDX_W-1:0] slot_idx   [SLOT_COUNT];
  logic [NB-1:0]    entry_name [ENTRY_CAPACITY];

  logic                 kind_q;
  logic [KEY_W-1:0]     key_q;
  logic [NB-1:0]        name_q;
  logic [KEY_W-1:0]     key_rd_q;
  logic [IDX_W-1:0]     idx_rd_q;
  logic [NB-1:0]        name_rd_q;
  logic [SLOT_BITS-1:0] slot_q;
  logic [SLOT_BITS-1:0] probe_q;
  logic [CNT_W-1:0]     count_q;
  logic [STATUS_W-1:0]  status_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [31:0]          new_handle;
  logic [31:0]          slot_handle;

  assign new_handle  = 32'(count_q) + 32'(HANDLE_BASE);
  assign slot_handle = 32'(idx_rd_q) + 32'(HANDLE_BASE);

  // Memories: registered reads, single write port each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      slot_key[slot_q] <= '0;
    end else if (cmd_i.insert) begin
      slot_key[slot_q] <= key_q;
      slot_idx[slot_q] <= count_q[IDX_W-1:0];
    end
    if (cmd_i.insert) begin
      entry_name[count_q[IDX_W-1:0]] <= name_q;
    end
    if (cmd_i.rd_slot) begin
      key_rd_q <= slot_key[slot_q];
      idx_rd_q <= slot_idx[slot_q];
    end
    if (cmd_i.rd_name) begin
      name_rd_q <= entry_name[idx_rd_q];
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      name_q  <= name_id_i[NB-1:0];
      probe_q <= '0;
    end else if (cmd_i.step) begin
      probe_q <= probe_q + 1'b1;
    end
    if (cmd_i.res_load) begin
      status_q <= cmd_i.res_status;
      case (cmd_i.res_sel)
        RES_NEW:  handle_q <= new_handle[HANDLE_W-1:0];
        RES_SLOT: handle_q <= slot_handle[HANDLE_W-1:0];
        default:  handle_q <= '0;
      endcase
    end
  end

  // Slot pointer doubles as the clearing pointer after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.load_item) begin
        slot_q <= key_i[SLOT_BITS-1:0];
      end else if (cmd_i.clear || cmd_i.step) begin
        slot_q <= slot_q + 1'b1;
      end
      if (cmd_i.insert) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_comb begin
    sts_o.is_insert   = kind_q;
    sts_o.key_zero    = (key_q == '0);
    sts_o.slot_empty  = (key_rd_q == '0);
    sts_o.key_match   = (key_rd_q == key_q);
    sts_o.name_match  = (name_rd_q == name_q);
    sts_o.entry_avail = (count_q < CNT_W'(ENTRY_CAPACITY));
    sts_o.last_probe  = (probe_q == SLOT_BITS'(SLOT_COUNT - 2));
    sts_o.last_slot   = &slot_q;
  end

  assign status_o = status_q;
  assign handle_o = handle_q;

endmodule

// File: rtl/lpdt_ctrl.sv
// Controller: clearing pass, probe sequencing, result handshake.
`timescale 1ns / 1ps
module lpdt_ctrl import lpdt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_START    = 3'd2;
  localparam logic [2:0] S_CHK_SLOT = 3'd3;
  localparam logic [2:0] S_CHK_NAME = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.last_slot) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_START;
        end
      end
      S_START: begin
        if (sts_i.key_zero) begin
          if (out_free) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_MISS;
            cmd_o.res_sel    = RES_NONE;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.rd_slot = 1'b1;
          state_d       = S_CHK_SLOT;
        end
      end
      S_CHK_SLOT: begin
        if (sts_i.slot_empty) begin
          if (out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_NONE;
            state_d        = S_IDLE;
            if (!sts_i.is_insert) begin
              cmd_o.res_status = ST_MISS;
            end else if (sts_i.entry_avail) begin
              cmd_o.insert     = 1'b1;
              cmd_o.res_status = ST_HIT;
              cmd_o.res_sel    = RES_NEW;
            end else begin
              cmd_o.res_status = ST_FULL;
            end
          end
        end else if (sts_i.key_match) begin
          cmd_o.rd_name = 1'b1;
          state_d       = S_CHK_NAME;
        end else if (sts_i.last_probe) begin
          if (out_free) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_FULL;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_START;
        end
      end
      S_CHK_NAME: begin
        if (sts_i.name_match) begin
          if (out_free) begin
            cmd_o.res_load = 1'b1;
            state_d        = S_IDLE;
            if (sts_i.is_insert) begin
              cmd_o.res_status = ST_DUP;
              cmd_o.res_sel    = RES_NONE;
            end else begin
              cmd_o.res_status = ST_HIT;
              cmd_o.res_sel    = RES_SLOT;
            end
          end
        end else if (sts_i.last_probe) begin
          if (out_free) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_FULL;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_START;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.res_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/linear_probe_define_table.sv
// Top level of the linear-probe define table: controller, datapath and checks.
// Sequence: after the accept, each probed slot is read in S_START and checked in
//   S_CHK_SLOT, plus S_CHK_NAME on a key match (a zero key ends in S_START); the
//   registered result beat shows the cycle after the decision. A new request is taken only
//   back in S_IDLE, after the probe walk; a waiting result does not block the next accept.
// Reset: slot keys cleared by a pass over all 2^SLOT_BITS slots (512 at default), in ready low.
`timescale 1ns / 1ps
module linear_probe_define_table import lpdt_pkg::*; #(
  parameter int SLOT_BITS      = 9,
  parameter int ENTRY_CAPACITY = 256,
  parameter int NAME_BITS      = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lpdt_in_if.sink      in_i,
  lpdt_out_if.source   out_o
);

  cmd_t cmd;
  sts_t sts;
  logic out_valid;

  // Sequencer: owns the clearing pass, the probe walk and the result beat.
  lpdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Memories and registers: slot keys, slot entry indexes, entry names.
  // The entry count resets to zero at once.
  lpdt_dp #(
    .SLOT_BITS      (SLOT_BITS),
    .ENTRY_CAPACITY (ENTRY_CAPACITY),
    .NAME_BITS      (NAME_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .kind_i    (in_i.kind),
    .key_i     (in_i.key),
    .name_id_i (in_i.name_id),
    .status_o  (out_o.status),
    .handle_o  (out_o.handle)
  );

  assign out_o.valid = out_valid;

  // An insert only lands on an empty slot with define memory left.
  a_insert_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert |-> (sts.slot_empty && sts.entry_avail))
    else $error("insert without empty slot or free entry");

  // The result register is never overwritten while a beat still waits.
  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> (!out_valid || out_o.ready))
    else $error("result overwritten while pending");

  // No request is taken during the clearing pass.
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !in_i.ready)
    else $error("request accepted during clear");

  // Only a hit or an insert carries a handle.
  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && (out_o.status != ST_HIT)) |-> (out_o.handle == '0))
    else $error("nonzero handle on non-hit result");

endmodule
